// ===== sv/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
// No dependencies; every other file in the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  // A delta time or a length ends after this many bytes at most.
  localparam int unsigned MAX_VLQ_BYTES = 4;
  localparam int unsigned VLQ_CNT_W     = 3;
  localparam int unsigned VLQ_W         = 28;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned TEMPO_W       = 24;

  // Event queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO       = 8'h51;
  localparam logic [7:0] META_END_TRACK   = 8'h2F;
  localparam logic [3:0] HI_NOTE_OFF      = 4'h8;
  localparam logic [3:0] HI_NOTE_ON       = 4'h9;
  localparam logic [3:0] HI_POLY_PRESS    = 4'hA;
  localparam logic [3:0] HI_CONTROL       = 4'hB;
  localparam logic [3:0] HI_PROGRAM       = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS    = 4'hD;
  localparam logic [3:0] HI_SYSTEM        = 4'hF;

  typedef enum logic [8:0] {
    PH_DELTA     = 9'b000000001,
    PH_STATUS    = 9'b000000010,
    PH_DATA1     = 9'b000000100,
    PH_DATA2     = 9'b000001000,
    PH_META_TYPE = 9'b000010000,
    PH_META_LEN  = 9'b000100000,
    PH_SYSEX_LEN = 9'b001000000,
    PH_SKIP      = 9'b010000000,
    PH_TEMPO     = 9'b100000000
  } phase_e;

  typedef enum logic [3:0] {
    KIND_NOTE_OFF    = 4'd0,
    KIND_NOTE_ON     = 4'd1,
    KIND_POLY_PRESS  = 4'd2,
    KIND_CONTROL     = 4'd3,
    KIND_PROGRAM     = 4'd4,
    KIND_CHAN_PRESS  = 4'd5,
    KIND_PITCH_BEND  = 4'd6,
    KIND_TEMPO       = 4'd7,
    KIND_END_TRACK   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ENTRY_CHANNEL   = 2'd0,
    ENTRY_TEMPO     = 2'd1,
    ENTRY_END_TRACK = 2'd2
  } entry_kind_e;

  // One parsed event as it travels from the parser to the output stage.
  typedef struct packed {
    logic [TICK_W-1:0]  tick;
    entry_kind_e        kind;
    logic [7:0]         status;
    logic [7:0]         data1;
    logic [7:0]         data2;
    logic [TEMPO_W-1:0] tempo;
  } entry_t;

  function automatic logic is_one_data(input logic [3:0] hi);
    return (hi == HI_PROGRAM) || (hi == HI_CHAN_PRESS);
  endfunction

endpackage

`default_nettype wire

// ===== sv/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: parser front end, event queue
// and output stage. Depends on mtep_pkg, mtep_front, mtep_queue, mtep_back.
//
//   Channel   Direction  Handshake                    Payload
//   track     in         track_valid_i / track_ready_o  track_byte_i, track_end_i
//   event     out        event_valid_o / event_ready_i  event_tick_o, event_kind_o,
//                                                     midi_channel_o, first_data_o,
//                                                     second_data_o, tempo_micros_o
//
// One track beat is taken every cycle; the parser updates its state in the
// cycle of the beat, so the rate is set by nothing but the queue having room.
// An event is written into the queue when the beat completing it is accepted,
// and its valid rises once the output register has taken it from the queue.
// A two-entry queue sits between parser and output register, so the input
// stalls only when the queue is full while the output side is held up.
// Reset is asynchronous and active low; the beat marked track_end_i also
// returns the parser to its reset state once it has been handled.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         track_valid_i,
  output logic              track_ready_o,
  input  wire logic [7:0]   track_byte_i,
  input  wire logic         track_end_i,
  output logic              event_valid_o,
  input  wire logic         event_ready_i,
  output logic [31:0]       event_tick_o,
  output logic [3:0]        event_kind_o,
  output logic [3:0]        midi_channel_o,
  output logic [7:0]        first_data_o,
  output logic [7:0]        second_data_o,
  output logic [23:0]       tempo_micros_o
);

  logic              q_not_full;
  logic              q_not_empty;
  logic              push;
  logic              pop;
  mtep_pkg::entry_t  push_entry;
  mtep_pkg::entry_t  head;

  mtep_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (track_valid_i),
    .in_ready_o   (track_ready_o),
    .track_byte_i (track_byte_i),
    .track_end_i  (track_end_i),
    .q_ready_i    (q_not_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  mtep_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .not_full_o   (q_not_full),
    .pop_i        (pop),
    .not_empty_o  (q_not_empty),
    .head_o       (head)
  );

  mtep_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_not_empty_i  (q_not_empty),
    .head_i         (head),
    .pop_o          (pop),
    .event_valid_o  (event_valid_o),
    .event_ready_i  (event_ready_i),
    .event_tick_o   (event_tick_o),
    .event_kind_o   (event_kind_o),
    .midi_channel_o (midi_channel_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .tempo_micros_o (tempo_micros_o)
  );

endmodule

`default_nettype wire

// ===== sv/mtep_front.sv =====
// Parser front end: takes track bytes, keeps all parse state and pushes
// finished events into the event queue. Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      track_byte_i,
  input  wire logic            track_end_i,
  input  wire logic            q_ready_i,
  output logic                 push_o,
  output mtep_pkg::entry_t     entry_o
);

  mtep_pkg::phase_e                      phase_q, phase_d;
  logic [mtep_pkg::VLQ_W-1:0]            vlq_q, vlq_d;
  logic [mtep_pkg::VLQ_CNT_W-1:0]        vlq_cnt_q, vlq_cnt_d;
  logic [mtep_pkg::TICK_W-1:0]           tick_q, tick_d;
  logic [7:0]                            running_q, running_d;
  logic [7:0]                            current_q, current_d;
  logic [7:0]                            held_q, held_d;
  logic [7:0]                            meta_q, meta_d;
  logic [mtep_pkg::VLQ_W-1:0]            skip_q, skip_d;
  logic [mtep_pkg::TEMPO_W-1:0]          tempo_q, tempo_d;
  logic [1:0]                            tempo_cnt_q, tempo_cnt_d;
  logic                                  halted_q, halted_d;
  logic                                  accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    logic [mtep_pkg::VLQ_W-1:0]     vlq_new;
    logic [mtep_pkg::VLQ_CNT_W-1:0] cnt_new;
    logic                           vlq_done;
    logic                           reuse;
    logic [7:0]                     st;
    logic [3:0]                     hi;
    logic [mtep_pkg::TEMPO_W-1:0]   tempo_new;
    logic [1:0]                     tcnt_new;

    phase_d     = phase_q;
    vlq_d       = vlq_q;
    vlq_cnt_d   = vlq_cnt_q;
    tick_d      = tick_q;
    running_d   = running_q;
    current_d   = current_q;
    held_d      = held_q;
    meta_d      = meta_q;
    skip_d      = skip_q;
    tempo_d     = tempo_q;
    tempo_cnt_d = tempo_cnt_q;
    halted_d    = halted_q;

    push_o         = 1'b0;
    entry_o.tick   = tick_q;
    entry_o.kind   = mtep_pkg::ENTRY_CHANNEL;
    entry_o.status = current_q;
    entry_o.data1  = held_q;
    entry_o.data2  = track_byte_i;
    entry_o.tempo  = '0;

    vlq_new  = {vlq_q[mtep_pkg::VLQ_W-8:0], track_byte_i[6:0]};
    cnt_new  = vlq_cnt_q + mtep_pkg::VLQ_CNT_W'(1);
    vlq_done = !track_byte_i[7] ||
               (cnt_new >= mtep_pkg::VLQ_CNT_W'(mtep_pkg::MAX_VLQ_BYTES));
    reuse    = !track_byte_i[7];
    st       = reuse ? running_q : track_byte_i;
    hi       = st[7:4];
    tempo_new = {tempo_q[mtep_pkg::TEMPO_W-9:0], track_byte_i};
    tcnt_new  = tempo_cnt_q + 2'd1;

    if (accept && !halted_q) begin
      unique case (phase_q)
        mtep_pkg::PH_DELTA: begin
          if (vlq_done) begin
            tick_d    = tick_q + mtep_pkg::TICK_W'(vlq_new);
            vlq_d     = '0;
            vlq_cnt_d = '0;
            phase_d   = mtep_pkg::PH_STATUS;
          end else begin
            vlq_d     = vlq_new;
            vlq_cnt_d = cnt_new;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (!reuse) begin
            running_d = track_byte_i;
          end
          current_d = st;
          if (st == mtep_pkg::STATUS_META) begin
            if (reuse) begin
              // The byte is already the meta type.
              meta_d  = track_byte_i;
              phase_d = mtep_pkg::PH_META_LEN;
              if (track_end_i && track_byte_i == mtep_pkg::META_END_TRACK) begin
                push_o       = 1'b1;
                entry_o.kind = mtep_pkg::ENTRY_END_TRACK;
              end
            end else begin
              phase_d = mtep_pkg::PH_META_TYPE;
            end
          end else if (st == mtep_pkg::STATUS_SYSEX || st == mtep_pkg::STATUS_SYSEX_ESC) begin
            phase_d = mtep_pkg::PH_SYSEX_LEN;
            if (reuse) begin
              // The byte is already the first length byte.
              if (vlq_done) begin
                vlq_d     = '0;
                vlq_cnt_d = '0;
                skip_d    = vlq_new;
                phase_d   = (vlq_new != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
              end else begin
                vlq_d     = vlq_new;
                vlq_cnt_d = cnt_new;
              end
            end
          end else if (st[7] && hi != mtep_pkg::HI_SYSTEM) begin
            if (!reuse) begin
              phase_d = mtep_pkg::PH_DATA1;
            end else begin
              held_d = track_byte_i;
              if (mtep_pkg::is_one_data(hi)) begin
                phase_d        = mtep_pkg::PH_DELTA;
                push_o         = 1'b1;
                entry_o.status = st;
                entry_o.data1  = track_byte_i;
                entry_o.data2  = 8'h00;
              end else begin
                phase_d = mtep_pkg::PH_DATA2;
              end
            end
          end else begin
            halted_d = 1'b1;
          end
        end
        mtep_pkg::PH_DATA1: begin
          held_d = track_byte_i;
          if (mtep_pkg::is_one_data(current_q[7:4])) begin
            phase_d       = mtep_pkg::PH_DELTA;
            push_o        = 1'b1;
            entry_o.data1 = track_byte_i;
            entry_o.data2 = 8'h00;
          end else begin
            phase_d = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          phase_d = mtep_pkg::PH_DELTA;
          push_o  = 1'b1;
        end
        mtep_pkg::PH_META_TYPE: begin
          meta_d  = track_byte_i;
          phase_d = mtep_pkg::PH_META_LEN;
          if (track_end_i && track_byte_i == mtep_pkg::META_END_TRACK) begin
            push_o       = 1'b1;
            entry_o.kind = mtep_pkg::ENTRY_END_TRACK;
          end
        end
        mtep_pkg::PH_META_LEN: begin
          if (vlq_done) begin
            vlq_d     = '0;
            vlq_cnt_d = '0;
            if (meta_q == mtep_pkg::META_TEMPO && vlq_new == mtep_pkg::VLQ_W'(3)) begin
              tempo_d     = '0;
              tempo_cnt_d = '0;
              phase_d     = mtep_pkg::PH_TEMPO;
            end else begin
              skip_d  = vlq_new;
              phase_d = (vlq_new != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
              if (meta_q == mtep_pkg::META_END_TRACK) begin
                push_o       = 1'b1;
                entry_o.kind = mtep_pkg::ENTRY_END_TRACK;
              end
            end
          end else begin
            vlq_d     = vlq_new;
            vlq_cnt_d = cnt_new;
            // An end-of-track cut off inside its length is still reported.
            if (track_end_i && meta_q == mtep_pkg::META_END_TRACK) begin
              push_o       = 1'b1;
              entry_o.kind = mtep_pkg::ENTRY_END_TRACK;
            end
          end
        end
        mtep_pkg::PH_SYSEX_LEN: begin
          if (vlq_done) begin
            vlq_d     = '0;
            vlq_cnt_d = '0;
            skip_d    = vlq_new;
            phase_d   = (vlq_new != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
          end else begin
            vlq_d     = vlq_new;
            vlq_cnt_d = cnt_new;
          end
        end
        mtep_pkg::PH_SKIP: begin
          skip_d = skip_q - mtep_pkg::VLQ_W'(1);
          if (skip_q == mtep_pkg::VLQ_W'(1)) begin
            phase_d = mtep_pkg::PH_DELTA;
          end
        end
        mtep_pkg::PH_TEMPO: begin
          tempo_d     = tempo_new;
          tempo_cnt_d = tcnt_new;
          if (tcnt_new == 2'd3) begin
            push_o        = 1'b1;
            entry_o.kind  = mtep_pkg::ENTRY_TEMPO;
            entry_o.tempo = tempo_new;
            tempo_d       = '0;
            tempo_cnt_d   = '0;
            phase_d       = mtep_pkg::PH_DELTA;
          end
        end
        default: begin
          phase_d = mtep_pkg::PH_DELTA;
        end
      endcase
    end

    // The last beat of a track returns every piece of parse state to reset.
    if (accept && track_end_i) begin
      phase_d     = mtep_pkg::PH_DELTA;
      vlq_d       = '0;
      vlq_cnt_d   = '0;
      tick_d      = '0;
      running_d   = '0;
      current_d   = '0;
      held_d      = '0;
      meta_d      = '0;
      skip_d      = '0;
      tempo_d     = '0;
      tempo_cnt_d = '0;
      halted_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mtep_pkg::PH_DELTA;
      vlq_q       <= '0;
      vlq_cnt_q   <= '0;
      tick_q      <= '0;
      running_q   <= '0;
      current_q   <= '0;
      held_q      <= '0;
      meta_q      <= '0;
      skip_q      <= '0;
      tempo_q     <= '0;
      tempo_cnt_q <= '0;
      halted_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      vlq_q       <= vlq_d;
      vlq_cnt_q   <= vlq_cnt_d;
      tick_q      <= tick_d;
      running_q   <= running_d;
      current_q   <= current_d;
      held_q      <= held_d;
      meta_q      <= meta_d;
      skip_q      <= skip_d;
      tempo_q     <= tempo_d;
      tempo_cnt_q <= tempo_cnt_d;
      halted_q    <= halted_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtep_queue.sv =====
// Short event queue between the parser and the output stage.
// Depends on mtep_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mtep_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mtep_pkg::entry_t  push_entry_i,
  output logic                   not_full_o,
  input  wire logic              pop_i,
  output logic                   not_empty_o,
  output mtep_pkg::entry_t       head_o
);

  mtep_pkg::entry_t                   mem_q [mtep_pkg::QUEUE_DEPTH];
  logic [mtep_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mtep_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mtep_pkg::QUEUE_CNT_W-1:0]   count_q, count_d;

  assign not_full_o  = count_q != mtep_pkg::QUEUE_CNT_W'(mtep_pkg::QUEUE_DEPTH);
  assign not_empty_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mtep_pkg::QUEUE_PTR_W'(mtep_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + mtep_pkg::QUEUE_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mtep_pkg::QUEUE_PTR_W'(mtep_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + mtep_pkg::QUEUE_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + mtep_pkg::QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - mtep_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtep_back.sv =====
// Output stage: decodes queued events into event kinds and fields and
// holds them in the output register. Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_not_empty_i,
  input  wire mtep_pkg::entry_t              head_i,
  output logic                               pop_o,
  output logic                               event_valid_o,
  input  wire logic                          event_ready_i,
  output logic [mtep_pkg::TICK_W-1:0]        event_tick_o,
  output logic [3:0]                         event_kind_o,
  output logic [3:0]                         midi_channel_o,
  output logic [7:0]                         first_data_o,
  output logic [7:0]                         second_data_o,
  output logic [mtep_pkg::TEMPO_W-1:0]       tempo_micros_o
);

  logic                            valid_q;
  logic [mtep_pkg::TICK_W-1:0]     tick_q;
  mtep_pkg::kind_e                 kind_q, kind_d;
  logic [3:0]                      chan_q, chan_d;
  logic [7:0]                      d1_q, d1_d;
  logic [7:0]                      d2_q, d2_d;
  logic [mtep_pkg::TEMPO_W-1:0]    tempo_q, tempo_d;

  assign pop_o = q_not_empty_i && (!valid_q || event_ready_i);

  always_comb begin
    kind_d  = mtep_pkg::KIND_PITCH_BEND;
    chan_d  = 4'h0;
    d1_d    = 8'h00;
    d2_d    = 8'h00;
    tempo_d = '0;
    unique case (head_i.kind)
      mtep_pkg::ENTRY_TEMPO: begin
        kind_d  = mtep_pkg::KIND_TEMPO;
        tempo_d = head_i.tempo;
      end
      mtep_pkg::ENTRY_END_TRACK: begin
        kind_d = mtep_pkg::KIND_END_TRACK;
      end
      default: begin
        chan_d = head_i.status[3:0];
        d1_d   = head_i.data1;
        d2_d   = head_i.data2;
        unique case (head_i.status[7:4])
          mtep_pkg::HI_NOTE_OFF:   kind_d = mtep_pkg::KIND_NOTE_OFF;
          // A note-on with zero velocity means note-off.
          mtep_pkg::HI_NOTE_ON:    kind_d = (head_i.data2 == 8'h00) ?
                                            mtep_pkg::KIND_NOTE_OFF : mtep_pkg::KIND_NOTE_ON;
          mtep_pkg::HI_POLY_PRESS: kind_d = mtep_pkg::KIND_POLY_PRESS;
          mtep_pkg::HI_CONTROL:    kind_d = mtep_pkg::KIND_CONTROL;
          mtep_pkg::HI_PROGRAM:    kind_d = mtep_pkg::KIND_PROGRAM;
          mtep_pkg::HI_CHAN_PRESS: kind_d = mtep_pkg::KIND_CHAN_PRESS;
          default:                 kind_d = mtep_pkg::KIND_PITCH_BEND;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tick_q  <= head_i.tick;
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
      tempo_q <= tempo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (event_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign event_valid_o  = valid_q;
  assign event_tick_o   = tick_q;
  assign event_kind_o   = kind_q;
  assign midi_channel_o = chan_q;
  assign first_data_o   = d1_q;
  assign second_data_o  = d2_q;
  assign tempo_micros_o = tempo_q;

endmodule

`default_nettype wire

// ===== sv/mtep_checker.sv =====
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser.
`timescale 1ns / 1ps
`default_nettype none

module mtep_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         event_valid_o,
  input wire logic         event_ready_i,
  input wire logic [31:0]  event_tick_o,
  input wire logic [3:0]   event_kind_o,
  input wire logic [3:0]   midi_channel_o,
  input wire logic [7:0]   first_data_o,
  input wire logic [7:0]   second_data_o,
  input wire logic [23:0]  tempo_micros_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && !event_ready_i |=> event_valid_o)
    else $error("event beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && !event_ready_i |=>
      $stable(event_tick_o) && $stable(event_kind_o) && $stable(tempo_micros_o))
    else $error("event payload changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o |-> event_kind_o <= mtep_pkg::KIND_END_TRACK)
    else $error("event kind out of range");

  a_meta_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && (event_kind_o == mtep_pkg::KIND_TEMPO ||
                      event_kind_o == mtep_pkg::KIND_END_TRACK) |->
      midi_channel_o == 4'h0 && first_data_o == 8'h00 && second_data_o == 8'h00)
    else $error("meta event carries channel fields");

  a_tempo_only_for_tempo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o != mtep_pkg::KIND_TEMPO |-> tempo_micros_o == 24'h0)
    else $error("tempo field set on a non-tempo event");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);

`default_nettype wire

// ===== tb/midi_track_event_parser_tb.sv =====
// Self-checking testbench for midi_track_event_parser: directed and random track bytes
// in, decoded events checked against an in-bench parser model held in a scoreboard class.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
`timescale 1ns / 1ps

module midi_track_event_parser_tb;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned TARGET_BEATS = 850;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned SEND_IDLE[4]  = '{0, 78, 0, 11};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 78, 11};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        track_valid_i = 1'b0;
  logic        track_ready_o;
  logic [7:0]  track_byte_i  = 8'h00;
  logic        track_end_i   = 1'b0;
  logic        event_valid_o;
  logic        event_ready_i = 1'b0;
  logic [31:0] event_tick_o;
  logic [3:0]  event_kind_o;
  logic [3:0]  midi_channel_o;
  logic [7:0]  first_data_o;
  logic [7:0]  second_data_o;
  logic [23:0] tempo_micros_o;

  typedef struct packed {
    logic [31:0]       tick;
    mtep_pkg::kind_e   kind;
    logic [3:0]        channel;
    logic [7:0]        data1;
    logic [7:0]        data2;
    logic [23:0]       tempo;
  } midi_event_t;

  class track_event_scoreboard;
    midi_event_t       pending_events[$];
    int                errors;
    mtep_pkg::phase_e  phase;
    logic [27:0]       vlq_acc;
    logic [2:0]        vlq_cnt;
    logic [31:0]       tick;
    logic [7:0]        run_status;
    logic [7:0]        cur_status;
    logic [7:0]        held_data1;
    logic [7:0]        meta_type;
    logic [27:0]       skip_left;
    logic [23:0]       tempo_acc;
    logic [1:0]        tempo_cnt;
    logic              halted;

    function new();
      errors = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase      = mtep_pkg::PH_DELTA;
      vlq_acc    = '0;
      vlq_cnt    = '0;
      tick       = '0;
      run_status = '0;
      cur_status = '0;
      held_data1 = '0;
      meta_type  = '0;
      skip_left  = '0;
      tempo_acc  = '0;
      tempo_cnt  = '0;
      halted     = 1'b0;
    endfunction

    // A variable-length value also ends once it has reached its byte limit.
    function bit vlq_push(logic [7:0] b);
      vlq_acc = {vlq_acc[20:0], b[6:0]};
      vlq_cnt = vlq_cnt + 3'd1;
      return !b[7] || (vlq_cnt >= mtep_pkg::MAX_VLQ_BYTES);
    endfunction

    function logic [27:0] vlq_pop();
      logic [27:0] v;
      v = vlq_acc;
      vlq_acc = '0;
      vlq_cnt = '0;
      return v;
    endfunction

    function bit single_data(logic [3:0] hi);
      return (hi == mtep_pkg::HI_PROGRAM) || (hi == mtep_pkg::HI_CHAN_PRESS);
    endfunction

    function void push_event(mtep_pkg::kind_e kind, logic [3:0] channel, logic [7:0] d1,
                             logic [7:0] d2, logic [23:0] tempo);
      midi_event_t ev;
      ev.tick    = tick;
      ev.kind    = kind;
      ev.channel = channel;
      ev.data1   = d1;
      ev.data2   = d2;
      ev.tempo   = tempo;
      pending_events = {pending_events, ev};
    endfunction

    function void push_channel(logic [7:0] d2);
      mtep_pkg::kind_e kind;
      case (cur_status[7:4])
        mtep_pkg::HI_NOTE_OFF:   kind = mtep_pkg::KIND_NOTE_OFF;
        mtep_pkg::HI_NOTE_ON:    kind = (d2 == 8'd0) ? mtep_pkg::KIND_NOTE_OFF :
                                                       mtep_pkg::KIND_NOTE_ON;
        mtep_pkg::HI_POLY_PRESS: kind = mtep_pkg::KIND_POLY_PRESS;
        mtep_pkg::HI_CONTROL:    kind = mtep_pkg::KIND_CONTROL;
        mtep_pkg::HI_PROGRAM:    kind = mtep_pkg::KIND_PROGRAM;
        mtep_pkg::HI_CHAN_PRESS: kind = mtep_pkg::KIND_CHAN_PRESS;
        default:                 kind = mtep_pkg::KIND_PITCH_BEND;
      endcase
      push_event(kind, cur_status[3:0], held_data1, d2, '0);
    endfunction

    function void start_skip(logic [27:0] len);
      skip_left = len;
      phase = (len != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
    endfunction

    function void meta_type_in(logic [7:0] b, logic last);
      meta_type = b;
      phase = mtep_pkg::PH_META_LEN;
      if (last && b == mtep_pkg::META_END_TRACK) begin
        push_event(mtep_pkg::KIND_END_TRACK, '0, '0, '0, '0);
      end
    endfunction

    // Advances the parser model by one accepted track beat.
    function void note_beat(logic [7:0] b, logic last);
      logic        reuse;
      logic [7:0]  st;
      logic [27:0] len;
      if (!halted) begin
        case (phase)
          mtep_pkg::PH_DELTA: begin
            if (vlq_push(b)) begin
              tick = tick + 32'(vlq_pop());
              phase = mtep_pkg::PH_STATUS;
            end
          end
          mtep_pkg::PH_STATUS: begin
            reuse = !b[7];
            st = reuse ? run_status : b;
            if (!reuse) run_status = b;
            cur_status = st;
            if (st == mtep_pkg::STATUS_META) begin
              if (reuse) meta_type_in(b, last);
              else phase = mtep_pkg::PH_META_TYPE;
            end else if (st == mtep_pkg::STATUS_SYSEX || st == mtep_pkg::STATUS_SYSEX_ESC) begin
              phase = mtep_pkg::PH_SYSEX_LEN;
              if (reuse && vlq_push(b)) start_skip(vlq_pop());
            end else if (st[7:4] >= mtep_pkg::HI_NOTE_OFF && st[7:4] != mtep_pkg::HI_SYSTEM) begin
              if (!reuse) begin
                phase = mtep_pkg::PH_DATA1;
              end else begin
                held_data1 = b;
                if (single_data(st[7:4])) begin
                  phase = mtep_pkg::PH_DELTA;
                  push_channel(8'd0);
                end else begin
                  phase = mtep_pkg::PH_DATA2;
                end
              end
            end else begin
              // Unknown status, or running status with nothing to run on.
              halted = 1'b1;
            end
          end
          mtep_pkg::PH_DATA1: begin
            held_data1 = b;
            if (single_data(cur_status[7:4])) begin
              phase = mtep_pkg::PH_DELTA;
              push_channel(8'd0);
            end else begin
              phase = mtep_pkg::PH_DATA2;
            end
          end
          mtep_pkg::PH_DATA2: begin
            phase = mtep_pkg::PH_DELTA;
            push_channel(b);
          end
          mtep_pkg::PH_META_TYPE: meta_type_in(b, last);
          mtep_pkg::PH_META_LEN: begin
            if (vlq_push(b)) begin
              len = vlq_pop();
              if (meta_type == mtep_pkg::META_TEMPO && len == 28'd3) begin
                tempo_acc = '0;
                tempo_cnt = '0;
                phase = mtep_pkg::PH_TEMPO;
              end else begin
                start_skip(len);
                if (meta_type == mtep_pkg::META_END_TRACK) begin
                  push_event(mtep_pkg::KIND_END_TRACK, '0, '0, '0, '0);
                end
              end
            end else if (last && meta_type == mtep_pkg::META_END_TRACK) begin
              push_event(mtep_pkg::KIND_END_TRACK, '0, '0, '0, '0);
            end
          end
          mtep_pkg::PH_SYSEX_LEN: begin
            if (vlq_push(b)) start_skip(vlq_pop());
          end
          mtep_pkg::PH_SKIP: begin
            skip_left = skip_left - 28'd1;
            if (skip_left == '0) phase = mtep_pkg::PH_DELTA;
          end
          mtep_pkg::PH_TEMPO: begin
            tempo_acc = {tempo_acc[15:0], b};
            tempo_cnt = tempo_cnt + 2'd1;
            if (tempo_cnt == 2'd3) begin
              push_event(mtep_pkg::KIND_TEMPO, '0, '0, '0, tempo_acc);
              tempo_acc = '0;
              tempo_cnt = '0;
              phase = mtep_pkg::PH_DELTA;
            end
          end
          default: phase = mtep_pkg::PH_DELTA;
        endcase
      end
      if (last) clear_parser();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
    endfunction

    function void check_event(logic [31:0] tick_o, logic [3:0] kind_o, logic [3:0] chan_o,
                              logic [7:0] d1_o, logic [7:0] d2_o, logic [23:0] tempo_o);
      midi_event_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $error("event with none expected: tick 0x%0h kind %0d", tick_o, kind_o);
        return;
      end
      want = pending_events.pop_front();
      compare_field("event_tick", want.tick, tick_o);
      compare_field("event_kind", 32'(want.kind), 32'(kind_o));
      compare_field("midi_channel", 32'(want.channel), 32'(chan_o));
      compare_field("first_data", 32'(want.data1), 32'(d1_o));
      compare_field("second_data", 32'(want.data2), 32'(d2_o));
      compare_field("tempo_micros", 32'(want.tempo), 32'(tempo_o));
    endfunction
  endclass

  track_event_scoreboard track_events = new();

  logic [7:0]  gen_bytes[$];
  logic [7:0]  gen_status;
  int unsigned beats_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  midi_track_event_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .track_valid_i  (track_valid_i),
    .track_ready_o  (track_ready_o),
    .track_byte_i   (track_byte_i),
    .track_end_i    (track_end_i),
    .event_valid_o  (event_valid_o),
    .event_ready_i  (event_ready_i),
    .event_tick_o   (event_tick_o),
    .event_kind_o   (event_kind_o),
    .midi_channel_o (midi_channel_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .tempo_micros_o (tempo_micros_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && event_valid_o && event_ready_i) begin
      track_events.check_event(event_tick_o, event_kind_o, midi_channel_o, first_data_o,
                               second_data_o, tempo_micros_o);
    end
    event_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((track_valid_i && track_ready_o) || (event_valid_o && event_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_byte(logic [7:0] b);
    gen_bytes = {gen_bytes, b};
  endfunction

  function automatic logic [7:0] data_byte();
    return ($urandom_range(99) < 15) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
  endfunction

  function automatic void put_vlq(logic [27:0] v);
    logic [7:0] groups[$];
    groups.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != '0) begin
      groups.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (groups[i]) add_byte(groups[i]);
  endfunction

  // Near-maximal deltas make the tick wrap within one track.
  function automatic void put_delta(bit near_max);
    int unsigned r;
    r = $urandom_range(99);
    if (near_max) begin
      repeat (3) add_byte(8'hFF);
      add_byte(8'($urandom_range(255)));
    end else if (r < 5) begin
      repeat (4) add_byte({1'b1, 7'($urandom_range(127))});
    end else if (r < 55) begin
      put_vlq('0);
    end else if (r < 85) begin
      put_vlq(28'($urandom_range(1, 127)));
    end else begin
      put_vlq(28'($urandom_range(128, 28'h1FFFFF)));
    end
  endfunction

  function automatic void put_len_body(int unsigned len);
    put_vlq(28'(len));
    repeat (len) add_byte(8'($urandom_range(255)));
  endfunction

  function automatic int unsigned body_len();
    return ($urandom_range(99) < 3) ? $urandom_range(128, 200) : $urandom_range(0, 6);
  endfunction

  function automatic void put_event();
    int unsigned r;
    logic [3:0]  hi;
    logic [7:0]  mtype;
    r = $urandom_range(99);
    if (r < 55) begin
      if (r < 40 || gen_status[7:4] < mtep_pkg::HI_NOTE_OFF ||
          gen_status[7:4] == mtep_pkg::HI_SYSTEM) begin
        gen_status = {4'($urandom_range(8, 14)), 4'($urandom_range(15))};
        add_byte(gen_status);
        add_byte(data_byte());
      end else begin
        // Running status: the first data byte must look like data.
        add_byte(8'($urandom_range(127)));
      end
      hi = gen_status[7:4];
      if (!(hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_CHAN_PRESS)) begin
        add_byte(($urandom_range(99) < 15) ? 8'h00 : data_byte());
      end
    end else if (r < 63) begin
      gen_status = mtep_pkg::STATUS_META;
      add_byte(mtep_pkg::STATUS_META);
      add_byte(mtep_pkg::META_TEMPO);
      add_byte(8'd3);
      repeat (3) add_byte(8'($urandom_range(255)));
    end else if (r < 76) begin
      if (gen_status != mtep_pkg::STATUS_META || r < 70) begin
        gen_status = mtep_pkg::STATUS_META;
        add_byte(mtep_pkg::STATUS_META);
        mtype = 8'($urandom_range(255));
      end else begin
        mtype = 8'($urandom_range(127));
      end
      if ($urandom_range(9) == 0) mtype = mtep_pkg::META_TEMPO;
      add_byte(mtype);
      put_len_body((mtype == mtep_pkg::META_TEMPO && $urandom_range(1) == 0) ? 3 : body_len());
    end else if (r < 90) begin
      if ((gen_status == mtep_pkg::STATUS_SYSEX || gen_status == mtep_pkg::STATUS_SYSEX_ESC) &&
          r >= 84) begin
        put_len_body($urandom_range(0, 8));
      end else begin
        gen_status = $urandom_range(1) ? mtep_pkg::STATUS_SYSEX : mtep_pkg::STATUS_SYSEX_ESC;
        add_byte(gen_status);
        put_len_body(body_len());
      end
    end else if (r < 95) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
    end else begin
      gen_status = mtep_pkg::STATUS_META;
      add_byte(mtep_pkg::STATUS_META);
      add_byte(mtep_pkg::META_END_TRACK);
      add_byte(8'd0);
    end
  endfunction

  function automatic void build_track();
    bit          wrap_ticks;
    int unsigned keep;
    wrap_ticks = ($urandom_range(39) == 0);
    gen_bytes.delete();
    gen_status = 8'h00;
    repeat (wrap_ticks ? 18 : $urandom_range(1, 10)) begin
      put_delta(wrap_ticks);
      put_event();
    end
    if ($urandom_range(99) < 70) begin
      put_delta(1'b0);
      add_byte(mtep_pkg::STATUS_META);
      add_byte(mtep_pkg::META_END_TRACK);
      add_byte(8'd0);
    end
    // Some tracks stop in the middle of an event.
    if ($urandom_range(99) < 25) begin
      keep = $urandom_range(1, gen_bytes.size());
      while (gen_bytes.size() > keep) void'(gen_bytes.pop_back());
    end
  endfunction

  task automatic send_beat(logic [7:0] b, logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      track_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    track_valid_i <= 1'b1;
    track_byte_i  <= b;
    track_end_i   <= last;
    do @(posedge clk_i); while (!track_ready_o);
    track_events.note_beat(b, last);
    beats_sent++;
  endtask

  task automatic send_track();
    foreach (gen_bytes[i]) send_beat(gen_bytes[i], i == gen_bytes.size() - 1);
  endtask

  task automatic drain_events();
    track_valid_i <= 1'b0;
    while (track_events.pending_events.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Long delta with its last continuation bit set, velocity-zero note-on,
    // data bytes with the top bit set, tempo, and end-of-track cut short.
    gen_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h90, 8'h3C, 8'h00,
                 8'h00, 8'hEF, 8'hFF, 8'h80,
                 8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'hFF, 8'h2F};
    send_track();
    // Running status before any status byte, then an unknown status.
    gen_bytes = {8'h00, 8'h40, 8'h90};
    send_track();
    gen_bytes = {8'h00, 8'hF1, 8'h00};
    send_track();
    drain_events();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      while (beats_sent < (ph + 1) * TARGET_BEATS / 4) begin
        build_track();
        send_track();
      end
      drain_events();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (track_events.errors == 0 && track_events.pending_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
